/* hw/rtl/multi_rate_tick_divider_top_assert.svh */
// Assertion macros for the multi-rate tick divider.
`ifndef MULTI_RATE_TICK_DIVIDER_TOP_ASSERT_SVH
`define MULTI_RATE_TICK_DIVIDER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication in the same cycle.
`define MRTD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication in the next cycle.
`define MRTD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MRTD_ASSERT_IMP(name, ante, cons, msg)
`define MRTD_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

/* hw/rtl/mrtd_pkg.sv */
// Shared constants and types of the multi-rate tick divider.
package mrtd_pkg;

    localparam int RATE_W   = 26;
    localparam int CYC_W    = 12;
    localparam int TICK_W   = 13;
    localparam int PROD_W   = 38;
    localparam int PACC_W   = 30;
    localparam int ACC_W    = 31;
    localparam int PM_W     = 23;
    localparam int FRAME_W  = 21;
    localparam int POS_W    = 20;
    localparam int FR_REM_W = 6;
    localparam int CNT_W    = 6;
    localparam int IDX_W    = 2;

    localparam logic [TICK_W-1:0] TICK_MAX = 13'd8191;
    localparam logic [10:0] PULSE_STEP     = 11'd1203;
    localparam logic [6:0]  FRAME_DIV      = 7'd60;

    localparam logic [RATE_W-1:0] CORE_HZ_RST  = 26'd31334400;
    localparam logic [RATE_W-1:0] TIMER_HZ_RST = 26'd783360;
    localparam logic [RATE_W-1:0] MID_HZ_RST   = 26'd15667200;

    localparam logic [IDX_W-1:0] REG_CORE_HZ  = 2'd0;
    localparam logic [IDX_W-1:0] REG_TIMER_HZ = 2'd1;
    localparam logic [IDX_W-1:0] REG_MID_HZ   = 2'd2;

    // Sequencer schedule, counted from the cycle after the input transfer.
    localparam logic [CNT_W-1:0] CNT_MUL_LAST  = 6'd11;
    localparam logic [CNT_W-1:0] CNT_ADD       = 6'd12;
    localparam logic [CNT_W-1:0] CNT_DIV_FIRST = 6'd13;
    localparam logic [CNT_W-1:0] CNT_SAT_LAST  = 6'd37;
    localparam logic [CNT_W-1:0] CNT_DIV_LAST  = 6'd50;
    localparam logic [CNT_W-1:0] CNT_FIN       = 6'd51;
    localparam logic [CNT_W-1:0] CNT_FDIV_LAST = 6'd25;
    localparam logic [CNT_W-1:0] CNT_MOD_FIRST = 6'd26;
    localparam logic [CNT_W-1:0] CNT_MOD_LAST  = 6'd46;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic add_step;
        logic div_step;
        logic sat_win;
        logic commit;
        logic cyc_bit;
    } mrtd_ctrl_t;

endpackage

/* hw/rtl/mrtd_tick_div.sv */
// Bit-serial multiply and restoring divide for one tick divider, with its remainder.
module mrtd_tick_div
    import mrtd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mrtd_ctrl_t          ctrl,
    input  logic [RATE_W-1:0]   rate,
    input  logic [RATE_W-1:0]   core,
    output logic [TICK_W-1:0]   ticks
);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [RATE_W-1:0] part_reg, part_next;
    logic [RATE_W-1:0] rem_reg;
    logic [TICK_W-1:0] quo_reg, quo_next;
    logic              sat_reg, sat_next;
    logic [RATE_W:0]   trial;
    logic              ge;
    logic              core_zero;

    assign core_zero = (core == '0);
    assign trial     = {part_reg, prod_reg[PROD_W-1]};
    assign ge        = (trial >= {1'b0, core});

    always_comb
    begin
        prod_next = prod_reg;
        part_next = part_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        if (ctrl.load)
        begin
            prod_next = '0;
            part_next = '0;
            quo_next  = '0;
            sat_next  = 1'b0;
        end
        else if (ctrl.mul_step)
        begin
            prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                      + (ctrl.cyc_bit ? PROD_W'(rate) : '0);
        end
        else if (ctrl.add_step)
        begin
            prod_next = prod_reg + PROD_W'(rem_reg);
        end
        else if (ctrl.div_step)
        begin
            prod_next = {prod_reg[PROD_W-2:0], 1'b0};
            part_next = ge ? RATE_W'(trial - {1'b0, core}) : trial[RATE_W-1:0];
            quo_next  = {quo_reg[TICK_W-2:0], ge};
            // A quotient bit above the reported width means the count saturates.
            if (ctrl.sat_win && ge)
            begin
                sat_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (ctrl.commit && !core_zero)
        begin
            rem_reg <= part_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        part_reg <= part_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
    end

    assign ticks = core_zero ? '0 : (sat_reg ? TICK_MAX : quo_reg);

endmodule

/* hw/rtl/multi_rate_tick_divider_top.sv */
// Top level of the multi-rate tick divider.
//
// Input channel (s_*): one transfer carries the number of core clock cycles
// that passed since the previous item. Output channel (m_*): one result per
// input item, with the whole timer and mid clock ticks, the 60.15 Hz pulse
// flag and the vertical blanking level and its change.
// Configuration channel (cfg_*): writes core_hz, timer_hz or mid_hz by index;
// it is always ready. The user must see that it is written only while the
// block is idle; the block itself does not enforce this. Each item runs from
// its input transfer through bit-serial multiplication, an add of the stored
// remainders, restoring division by the core rate and a final step that
// loads the output register. The frame length and frame position are
// divided out serially in the same window. s_tready stays low for that
// time, so a new item is taken only once the previous one has finished.
// The result waits in an output register; if the receiver stalls, the next
// item is still taken and worked on, and it waits at its last step until the
// held result has been transferred.
// Reset restores the default rates and clears all remainders, the pulse
// accumulator, the frame position and the blanking level.
`include "multi_rate_tick_divider_top_assert.svh"

module multi_rate_tick_divider_top
    import mrtd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [11:0] elapsed_cycles
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [12:0] timer_ticks, [25:13] mid_ticks,
                                           // [26] pulse_6015, [27] blank_active,
                                           // [28] blank_changed
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [RATE_W-1:0]   cfg_data
);

    logic [RATE_W-1:0]   core_reg, timer_hz_reg, mid_hz_reg;
    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                in_fire, fin_fire;
    mrtd_ctrl_t          ctrl;

    logic [CYC_W-1:0]    cyc_sh_reg;
    logic [RATE_W-1:0]   core_sh_reg;
    logic [FR_REM_W-1:0] fr_rem_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [FRAME_W-1:0]  pos_sh_reg;
    logic [FRAME_W-1:0]  mod_rem_reg;
    logic [PM_W-1:0]     pm_reg;
    logic [ACC_W-1:0]    acc_reg, thr_reg;
    logic [PACC_W-1:0]   pacc_reg;
    logic [POS_W-1:0]    fpos_reg;
    logic                blank_level_reg;

    logic [FR_REM_W:0]   fr_trial;
    logic                fr_ge;
    logic [FRAME_W:0]    mod_trial;
    logic                mod_ge;
    logic                in_mul, in_fdiv, in_mod;

    logic [TICK_W-1:0]   timer_ticks, mid_ticks;
    logic                pulse_fire;
    logic [FRAME_W-1:0]  pos_inc;
    logic [RATE_W-1:0]   pos_x35, frame_x32;
    logic                frame_zero, blank_now;

    logic                m_tvalid_reg;
    logic [TICK_W-1:0]   out_timer_reg, out_mid_reg;
    logic                out_pulse_reg, out_blank_reg, out_changed_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign fin_fire  = busy_reg && (cnt_reg == CNT_FIN) && (!m_tvalid_reg || m_tready);

    assign in_mul  = busy_reg && (cnt_reg <= CNT_MUL_LAST);
    assign in_fdiv = busy_reg && (cnt_reg <= CNT_FDIV_LAST);
    assign in_mod  = busy_reg && (cnt_reg >= CNT_MOD_FIRST) && (cnt_reg <= CNT_MOD_LAST);

    always_comb
    begin
        ctrl.load     = in_fire;
        ctrl.mul_step = in_mul;
        ctrl.add_step = busy_reg && (cnt_reg == CNT_ADD);
        ctrl.div_step = busy_reg && (cnt_reg >= CNT_DIV_FIRST) && (cnt_reg <= CNT_DIV_LAST);
        ctrl.sat_win  = (cnt_reg <= CNT_SAT_LAST);
        ctrl.commit   = fin_fire;
        ctrl.cyc_bit  = cyc_sh_reg[CYC_W-1];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_reg     <= CORE_HZ_RST;
            timer_hz_reg <= TIMER_HZ_RST;
            mid_hz_reg   <= MID_HZ_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CORE_HZ:  core_reg     <= cfg_data;
                REG_TIMER_HZ: timer_hz_reg <= cfg_data;
                REG_MID_HZ:   mid_hz_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (in_fire)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (fin_fire)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && (cnt_reg != CNT_FIN))
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    mrtd_tick_div u_timer_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .rate  (timer_hz_reg),
        .core  (core_reg),
        .ticks (timer_ticks)
    );

    mrtd_tick_div u_mid_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .rate  (mid_hz_reg),
        .core  (core_reg),
        .ticks (mid_ticks)
    );

    // Frame length by serial division of the core rate by sixty, then the
    // frame position by serial modulo of that length.
    assign fr_trial  = {fr_rem_reg, core_sh_reg[RATE_W-1]};
    assign fr_ge     = (fr_trial >= FRAME_DIV);
    assign mod_trial = {mod_rem_reg, pos_sh_reg[FRAME_W-1]};
    assign mod_ge    = (mod_trial >= {1'b0, frame_reg});

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cyc_sh_reg  <= s_tdata[CYC_W-1:0];
            core_sh_reg <= core_reg;
            fr_rem_reg  <= '0;
            frame_reg   <= '0;
            pos_sh_reg  <= FRAME_W'(fpos_reg) + FRAME_W'(s_tdata[CYC_W-1:0]);
            mod_rem_reg <= '0;
            pm_reg      <= '0;
            thr_reg     <= ACC_W'({core_reg, 4'b0000}) + ACC_W'({core_reg, 2'b00});
        end
        else
        begin
            if (in_mul)
            begin
                cyc_sh_reg <= {cyc_sh_reg[CYC_W-2:0], 1'b0};
                pm_reg     <= {pm_reg[PM_W-2:0], 1'b0}
                            + (cyc_sh_reg[CYC_W-1] ? PM_W'(PULSE_STEP) : '0);
            end
            if (ctrl.add_step)
            begin
                acc_reg <= ACC_W'(pacc_reg) + ACC_W'(pm_reg);
            end
            if (in_fdiv)
            begin
                core_sh_reg <= {core_sh_reg[RATE_W-2:0], 1'b0};
                fr_rem_reg  <= fr_ge ? FR_REM_W'(fr_trial - FRAME_DIV)
                                     : fr_trial[FR_REM_W-1:0];
                frame_reg   <= {frame_reg[FRAME_W-2:0], fr_ge};
            end
            if (in_mod)
            begin
                pos_sh_reg  <= {pos_sh_reg[FRAME_W-2:0], 1'b0};
                mod_rem_reg <= mod_ge ? FRAME_W'(mod_trial - {1'b0, frame_reg})
                                      : mod_trial[FRAME_W-1:0];
            end
        end
    end

    // Blanking starts at frame * 32 / 35; pos >= floor(x / 35) is 35 * (pos + 1) > x.
    assign frame_zero = (frame_reg == '0);
    assign pos_inc    = FRAME_W'(mod_rem_reg[POS_W-1:0]) + 1'b1;
    assign pos_x35    = {pos_inc, 5'b00000} + RATE_W'({pos_inc, 1'b0}) + RATE_W'(pos_inc);
    assign frame_x32  = {frame_reg, 5'b00000};
    assign blank_now  = frame_zero || (pos_x35 > frame_x32);
    assign pulse_fire = (acc_reg >= thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pacc_reg        <= '0;
            fpos_reg        <= '0;
            blank_level_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            pacc_reg        <= pulse_fire ? PACC_W'(acc_reg - thr_reg) : acc_reg[PACC_W-1:0];
            fpos_reg        <= frame_zero ? '0 : mod_rem_reg[POS_W-1:0];
            blank_level_reg <= blank_now;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_timer_reg   <= timer_ticks;
            out_mid_reg     <= mid_ticks;
            out_pulse_reg   <= pulse_fire;
            out_blank_reg   <= blank_now;
            out_changed_reg <= blank_now ^ blank_level_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_changed_reg, out_blank_reg, out_pulse_reg,
                       out_mid_reg, out_timer_reg};

    `MRTD_ASSERT_NXT(a_accept_starts, in_fire, busy_reg && (cnt_reg == '0), "transfer did not start the sequencer")
    `MRTD_ASSERT_IMP(a_result_from_finish, $rose(m_tvalid_reg), $past(fin_fire), "result valid without a finished item")
    `MRTD_ASSERT_NXT(a_zero_core_no_ticks, fin_fire && (core_reg == '0), (out_timer_reg == '0) && (out_mid_reg == '0), "ticks reported with zero core rate")
    `MRTD_ASSERT_NXT(a_zero_frame_blank, fin_fire && frame_zero, out_blank_reg && (fpos_reg == '0), "zero frame length not reported as blanking")

endmodule

/* tb/multi_rate_tick_divider_top_tb.sv */
// Self-checking testbench for the multi-rate tick divider top level.
`timescale 1ns / 1ps

module multi_rate_tick_divider_top_tb;
    import mrtd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 60;

    // Result fields from the lowest bit up: timer ticks, mid ticks, pulse,
    // blanking level and blanking change.
    typedef struct packed {
        logic              blank_changed;
        logic              blank_active;
        logic              pulse_6015;
        logic [TICK_W-1:0] mid_ticks;
        logic [TICK_W-1:0] timer_ticks;
    } tick_report_t;

    typedef struct packed {
        logic [RATE_W-1:0] rem;
        logic [TICK_W-1:0] ticks;
    } tick_split_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;    // [11:0] elapsed_cycles
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;    // [12:0] timer_ticks, [25:13] mid_ticks,
                                     // [26] pulse_6015, [27] blank_active,
                                     // [28] blank_changed
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [RATE_W-1:0]   cfg_data;

    // Predicted state of the block.
    logic [RATE_W-1:0] core_rate;
    logic [RATE_W-1:0] timer_rate;
    logic [RATE_W-1:0] mid_rate;
    logic [RATE_W-1:0] timer_rem;
    logic [RATE_W-1:0] mid_rem;
    logic [PACC_W-1:0] pulse_acc;
    logic [POS_W-1:0]  frame_pos;
    logic              blank_prev;

    tick_report_t pending_reports[$];
    int           err_count;
    int           cycle_count;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           rx_hold;

    multi_rate_tick_divider_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Whole ticks of one slower clock, with the remainder carried exactly.
    function automatic tick_split_t whole_ticks(logic [RATE_W-1:0] rem,
                                                logic [RATE_W-1:0] rate,
                                                logic [CYC_W-1:0] cyc);
        logic [63:0] sum;
        logic [63:0] quot;
        tick_split_t res;
        res.rem   = rem;
        res.ticks = '0;
        if (core_rate != '0)
        begin
            sum       = 64'(rem) + 64'(cyc) * 64'(rate);
            quot      = sum / 64'(core_rate);
            res.rem   = RATE_W'(sum % 64'(core_rate));
            res.ticks = (quot > 64'(TICK_MAX)) ? TICK_MAX : TICK_W'(quot);
        end
        return res;
    endfunction

    function automatic tick_report_t advance_dividers(logic [CYC_W-1:0] cyc);
        tick_split_t  split;
        tick_report_t rep;
        logic [63:0]  acc;
        logic [63:0]  thr;
        logic [63:0]  frame_len;
        logic [63:0]  pos;
        logic         blank;
        split           = whole_ticks(timer_rem, timer_rate, cyc);
        timer_rem       = split.rem;
        rep.timer_ticks = split.ticks;

        // At most one threshold subtraction per item, even after the core
        // rate has been lowered below the accumulated value.
        acc            = 64'(pulse_acc) + 64'(cyc) * 64'(PULSE_STEP);
        thr            = 64'(core_rate) * 64'd20;
        rep.pulse_6015 = 1'b0;
        if (acc >= thr)
        begin
            acc            = acc - thr;
            rep.pulse_6015 = 1'b1;
        end
        pulse_acc = PACC_W'(acc);

        frame_len = 64'(core_rate) / 64'(FRAME_DIV);
        if (frame_len == '0)
        begin
            frame_pos = '0;
            blank     = 1'b1;
        end
        else
        begin
            pos       = (64'(frame_pos) + 64'(cyc)) % frame_len;
            frame_pos = POS_W'(pos);
            blank     = 64'(frame_pos) >= (frame_len * 64'd480) / 64'd525;
        end
        rep.blank_active  = blank;
        rep.blank_changed = blank != blank_prev;
        blank_prev        = blank;

        split         = whole_ticks(mid_rem, mid_rate, cyc);
        mid_rem       = split.rem;
        rep.mid_ticks = split.ticks;
        return rep;
    endfunction

    task automatic send_elapsed(input logic [CYC_W-1:0] cyc);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cyc};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        pending_reports.push_back(advance_dividers(cyc));
    endtask

    // Registers change only once every outstanding result has come back.
    task automatic write_rate(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_CORE_HZ:  core_rate  = val;
            REG_TIMER_HZ: timer_rate = val;
            REG_MID_HZ:   mid_rate   = val;
            default:      ;
        endcase
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] core, input logic [RATE_W-1:0] tim,
                             input logic [RATE_W-1:0] mid);
        write_rate(REG_CORE_HZ, core);
        write_rate(REG_TIMER_HZ, tim);
        write_rate(REG_MID_HZ, mid);
    endtask

    function automatic logic [RATE_W-1:0] pick_rate(logic [RATE_W-1:0] core);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RATE_W'(1);
            2:       return core;
            3:       return RATE_W'($urandom_range(core, 32'h3FF_FFFF));
            default: return RATE_W'($urandom_range(1, core));
        endcase
    endfunction

    function automatic logic [CYC_W-1:0] pick_cycles();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CYC_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Receiver side: draws its own stalls and checks every result transfer.
    initial
    begin : report_drain
        int           n;
        tick_report_t want;
        tick_report_t got;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            n = rx_idle_on ? $urandom_range(0, 6) : 0;
            repeat (n)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            got = tick_report_t'(m_tdata[28:0]);
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result %h with none expected", $time, m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.timer_ticks !== want.timer_ticks)
                begin
                    $display("%0t: timer_ticks expected %0d actual %0d",
                             $time, want.timer_ticks, got.timer_ticks);
                    err_count++;
                end
                if (got.mid_ticks !== want.mid_ticks)
                begin
                    $display("%0t: mid_ticks expected %0d actual %0d",
                             $time, want.mid_ticks, got.mid_ticks);
                    err_count++;
                end
                if (got.pulse_6015 !== want.pulse_6015)
                begin
                    $display("%0t: pulse_6015 expected %0d actual %0d",
                             $time, want.pulse_6015, got.pulse_6015);
                    err_count++;
                end
                if (got.blank_active !== want.blank_active)
                begin
                    $display("%0t: blank_active expected %0d actual %0d",
                             $time, want.blank_active, got.blank_active);
                    err_count++;
                end
                if (got.blank_changed !== want.blank_changed)
                begin
                    $display("%0t: blank_changed expected %0d actual %0d",
                             $time, want.blank_changed, got.blank_changed);
                    err_count++;
                end
            end
        end
    end

    task automatic test_reset_rates();
        send_elapsed(12'd0);
        send_elapsed(12'd4095);
        send_elapsed(12'd1);
        send_elapsed(12'hAAA);
        send_elapsed(12'h555);
        send_elapsed(12'd2048);
    endtask

    task automatic test_special_rates();
        // A zero core rate leaves the remainders alone and fires the pulse
        // on every item; the frame collapses to zero length.
        set_rates('0, RATE_W'(783360), RATE_W'(15667200));
        send_elapsed(12'd4095);
        send_elapsed(12'd17);
        // Core rate just under and exactly at sixty, the smallest rate with a nonzero frame.
        write_rate(REG_CORE_HZ, RATE_W'(59));
        send_elapsed(12'd100);
        send_elapsed(12'd0);
        write_rate(REG_CORE_HZ, RATE_W'(60));
        send_elapsed(12'd1);
        send_elapsed(12'd4095);
        // Rates far above the core rate saturate the tick counts.
        set_rates(RATE_W'(1000000), RATE_W'(50000000), 26'h3FF_FFFF);
        send_elapsed(12'd4095);
        send_elapsed(12'd3);
        // Build up large remainders, then drop the core rate beneath them.
        set_rates(26'h3FF_FFFF, RATE_W'(50000000), RATE_W'(1));
        send_elapsed(12'd4095);
        send_elapsed(12'd4000);
        write_rate(REG_CORE_HZ, RATE_W'(1000));
        send_elapsed(12'd5);
        send_elapsed(12'd4095);
    endtask

    task automatic test_backpressure();
        set_rates(RATE_W'(1000000), RATE_W'(999999), RATE_W'(333333));
        tx_idle_on = 1'b0;
        rx_hold    = 400;
        repeat (10) send_elapsed(pick_cycles());
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_rates();
        logic [RATE_W-1:0] core;
        int                count;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:       core = RATE_W'(1000000);
                1:       core = RATE_W'(50000000);
                2:       core = 26'h3FF_FFFF;
                3:       core = RATE_W'($urandom_range(60, 5000));
                default: core = RATE_W'($urandom_range(1000000, 50000000));
            endcase
            set_rates(core, pick_rate(core), pick_rate(core));
            tx_idle_on = (ph != 4);
            rx_idle_on = (ph != 4);
            // The oversized core rate needs long runs of large counts before
            // the pulse accumulator and frame position wrap.
            count = (ph == 2) ? 300 : 75;
            for (int i = 0; i < count; i++)
            begin
                if (ph == 2 && $urandom_range(0, 9) != 0)
                    send_elapsed(CYC_W'($urandom_range(3800, 4095)));
                else
                    send_elapsed(pick_cycles());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_CORE_HZ;
        cfg_data    <= '0;
        cycle_count <= 0;
        err_count   = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold     = 0;
        core_rate   = CORE_HZ_RST;
        timer_rate  = TIMER_HZ_RST;
        mid_rate    = MID_HZ_RST;
        timer_rem   = '0;
        mid_rem     = '0;
        pulse_acc   = '0;
        frame_pos   = '0;
        blank_prev  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_rates();
        test_special_rates();
        test_backpressure();
        test_random_rates();

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* multi_rate_tick_divider_top.f */
+incdir+hw/rtl
hw/rtl/mrtd_pkg.sv
hw/rtl/mrtd_tick_div.sv
hw/rtl/multi_rate_tick_divider_top.sv
tb/multi_rate_tick_divider_top_tb.sv
